FILE: rtl/lsa_database_admission_aging_core_macros.svh
// ----------------------------------------------------------------------------
// LSA database core assertion macros
// Shared implication checks, sampled on the rising clock edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LSA_DATABASE_ADMISSION_AGING_CORE_MACROS_SVH
`define LSA_DATABASE_ADMISSION_AGING_CORE_MACROS_SVH

// same-cycle implication
`define LSA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define LSA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// LSA database package
// Types, codes and constants shared by the table, the compare unit and the
// sequencer.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int ADDR_W      = 16;
    localparam int RID_W       = 8;
    localparam int SEQ_W       = 32;
    localparam int AGE_W       = 16;
    localparam int CNT_W       = 32;
    localparam int FLUSH_OUT_W = 9;
    localparam int ALU_W       = 32;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 160;

    localparam logic [AGE_W-1:0]       MAX_AGE_RST = 16'd3600;
    localparam logic [AGE_W-1:0]       AGE_SAT     = 16'hFFFF;
    localparam logic [FLUSH_OUT_W-1:0] FLUSH_SAT   = 9'd511;

    typedef enum logic [2:0] {
        ACT_OFFER     = 3'd0,
        ACT_REMOVE    = 3'd1,
        ACT_LOOKUP    = 3'd2,
        ACT_AGE       = 3'd3,
        ACT_FLUSH     = 3'd4,
        ACT_DROP      = 3'd5,
        ACT_CLEAR     = 3'd6,
        ACT_RESET_CNT = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_STALE    = 2'd1,
        STAT_DUP      = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SWEEP,
        S_DRAIN,
        S_WIPE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             neighbor;
        logic             valid;
        logic [AGE_W-1:0] age;
        logic [SEQ_W-1:0] seq;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W:0] sum;
        logic           lt;
        logic           eq;
    } alu_rsp_t;

    // packed MSB first, so found lands in bit 0 of tdata
    typedef struct packed {
        logic [CNT_W-1:0]       stale_total;
        logic [CNT_W-1:0]       duplicate_total;
        logic [CNT_W-1:0]       received_total;
        logic [FLUSH_OUT_W-1:0] flushed_count;
        logic                   is_neighbor;
        logic [AGE_W-1:0]       stored_age;
        logic [SEQ_W-1:0]       stored_seq;
        logic                   found;
    } res_t;

endpackage

FILE: rtl/lsa_alu.sv
// ----------------------------------------------------------------------------
// LSA shared compare and add unit
// One 32-bit adder and magnitude comparator, time-shared by the sequencer for
// offer admission, age increment and flush threshold checks.
// ----------------------------------------------------------------------------
module lsa_alu (
    input  lsa_pkg::alu_req_t req,
    output lsa_pkg::alu_rsp_t rsp
);

    always_comb begin
        rsp.sum = {1'b0, req.a} + {1'b0, req.b};
        rsp.lt  = req.a < req.b;
        rsp.eq  = req.a == req.b;
    end

endmodule

FILE: rtl/lsa_table.sv
// ----------------------------------------------------------------------------
// LSA entry table
// Single write port, single read port memory of advertisement entries with a
// registered read.
// ----------------------------------------------------------------------------
module lsa_table #(
    parameter int DEPTH = 256
) (
    input  logic             aclk,
    input  lsa_pkg::tbl_wr_t wr,
    input  lsa_pkg::tbl_rd_t rd,
    output lsa_pkg::entry_t  rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lsa_pkg::entry_t mem [DEPTH];
    lsa_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lsa_database_admission_aging_core.sv
// ----------------------------------------------------------------------------
// LSA database admission and aging core
// Per-router advertisement header table with admission by sequence number,
// aging, flushing and statistics counters.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per action (tuser = action, tdata = router, sequence,
//   age). m_ channel: one result beat per action (tuser = status).
//   cfg_ channel: max_age write, taken at any time, used by flush.
// Sequence, N = ROUTER_COUNT:
//   offer, remove, lookup, drop neighbour, reset counters: one table read,
//   then S_EVAL, then S_OUT; the next beat waits for S_IDLE.
//   age tick, flush: one table entry per cycle through the shared compare and
//   add unit, over all N entries. clear: zeroes all N entries.
//   The sweep length is set by the single read and single write port of the
//   table memory.
// Reset: aresetn (synchronous, active low) clears counters, sets max_age to
//   3600 and starts a clearing pass over all N entries; s_tready stays low meanwhile.
// Stall: the result sits in an output register; with m_tready low the next
//   beat is still accepted and processed, and waits before its result loads.
// ----------------------------------------------------------------------------
`include "lsa_database_admission_aging_core_macros.svh"

module lsa_database_admission_aging_core #(
    parameter int ROUTER_COUNT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,   // max_age
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,    // router_id[7:0], seq_number[39:8], lsa_age[55:40]
    input  logic [2:0]   s_tuser,    // action[2:0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,    // found[0], stored_seq[32:1], stored_age[48:33],
                                     // is_neighbor[49], flushed_count[58:50],
                                     // received_total[90:59], duplicate_total[122:91],
                                     // stale_total[154:123], zero pad[159:155]
    output logic [1:0]   m_tuser     // status[1:0]
);

    localparam int IDX_W = (ROUTER_COUNT > 1) ? $clog2(ROUTER_COUNT) : 1;
    localparam int FL_W  = $clog2(ROUTER_COUNT + 1);
    localparam int RW    = lsa_pkg::ADDR_W + 1;

    lsa_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] pipe_addr_reg, pipe_addr_next;

    lsa_pkg::action_t               act_reg, act_next;
    logic [lsa_pkg::RID_W-1:0]      rid_reg, rid_next;
    logic [lsa_pkg::SEQ_W-1:0]      seq_reg, seq_next;
    logic [lsa_pkg::AGE_W-1:0]      age_reg, age_next;
    logic [lsa_pkg::AGE_W-1:0]      max_age_reg, max_age_next;

    logic [lsa_pkg::CNT_W-1:0]      rx_cnt_reg, rx_cnt_next;
    logic [lsa_pkg::CNT_W-1:0]      dup_cnt_reg, dup_cnt_next;
    logic [lsa_pkg::CNT_W-1:0]      stale_cnt_reg, stale_cnt_next;
    logic [FL_W-1:0]                flush_cnt_reg, flush_cnt_next;

    lsa_pkg::res_t    res_reg, res_next;
    lsa_pkg::status_t res_status_reg, res_status_next;

    logic             m_tvalid_reg, m_tvalid_next;
    lsa_pkg::res_t    m_res_reg, m_res_next;
    lsa_pkg::status_t m_status_reg, m_status_next;
    logic             out_load;

    lsa_pkg::tbl_wr_t tbl_wr;
    lsa_pkg::tbl_rd_t tbl_rd;
    lsa_pkg::entry_t  ent;
    lsa_pkg::entry_t  upd_ent;
    lsa_pkg::alu_req_t alu_req;
    lsa_pkg::alu_rsp_t alu_rsp;

    logic [RW-1:0]    s_rid_wide;
    logic [RW-1:0]    rid_wide;
    logic             in_rng;
    logic             ptr_last;
    logic             ev_found;
    logic             ev_nb;

    lsa_table #(
        .DEPTH (ROUTER_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (ent)
    );

    lsa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_rid_wide = RW'(s_tdata[7:0]);
    assign rid_wide   = RW'(rid_reg);
    assign in_rng     = rid_wide < RW'(ROUTER_COUNT);
    assign ptr_last   = ptr_reg == IDX_W'(ROUTER_COUNT - 1);

    assign s_tready  = state_reg == lsa_pkg::S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = lsa_pkg::M_TDATA_W'(m_res_reg);
    assign m_tuser   = m_status_reg;

    assign max_age_next = cfg_valid ? cfg_data : max_age_reg;
    assign out_load     = (state_reg == lsa_pkg::S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        m_status_next = m_status_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res_reg;
            m_status_next = res_status_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pipe_vld_next   = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        act_next        = act_reg;
        rid_next        = rid_reg;
        seq_next        = seq_reg;
        age_next        = age_reg;
        rx_cnt_next     = rx_cnt_reg;
        dup_cnt_next    = dup_cnt_reg;
        stale_cnt_next  = stale_cnt_reg;
        flush_cnt_next  = flush_cnt_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        tbl_wr          = '0;
        tbl_rd          = '0;
        alu_req         = '0;
        upd_ent         = ent;
        ev_found        = 1'b0;
        ev_nb           = 1'b0;

        unique case (state_reg)
            lsa_pkg::S_INIT, lsa_pkg::S_WIPE: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = lsa_pkg::ADDR_W'(ptr_reg);
                tbl_wr.data = '0;
                ptr_next    = ptr_reg + IDX_W'(1);
                if (ptr_last) begin
                    ptr_next   = '0;
                    state_next = (state_reg == lsa_pkg::S_INIT) ? lsa_pkg::S_IDLE
                                                                : lsa_pkg::S_READ;
                end
            end
            lsa_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    act_next       = lsa_pkg::action_t'(s_tuser);
                    rid_next       = s_tdata[7:0];
                    seq_next       = s_tdata[39:8];
                    age_next       = s_tdata[55:40];
                    flush_cnt_next = '0;
                    ptr_next       = '0;
                    priority case (lsa_pkg::action_t'(s_tuser))
                        lsa_pkg::ACT_AGE, lsa_pkg::ACT_FLUSH: begin
                            state_next = lsa_pkg::S_SWEEP;
                        end
                        lsa_pkg::ACT_CLEAR: begin
                            state_next = lsa_pkg::S_WIPE;
                        end
                        default: begin
                            tbl_rd.en   = 1'b1;
                            tbl_rd.addr = s_rid_wide[lsa_pkg::ADDR_W-1:0];
                            state_next  = lsa_pkg::S_EVAL;
                        end
                    endcase
                end
            end
            lsa_pkg::S_READ: begin
                tbl_rd.en   = 1'b1;
                tbl_rd.addr = rid_wide[lsa_pkg::ADDR_W-1:0];
                state_next  = lsa_pkg::S_EVAL;
            end
            lsa_pkg::S_SWEEP: begin
                tbl_rd.en      = 1'b1;
                tbl_rd.addr    = lsa_pkg::ADDR_W'(ptr_reg);
                pipe_vld_next  = 1'b1;
                pipe_addr_next = ptr_reg;
                ptr_next       = ptr_reg + IDX_W'(1);
                if (ptr_last) begin
                    ptr_next   = '0;
                    state_next = lsa_pkg::S_DRAIN;
                end
            end
            lsa_pkg::S_DRAIN: begin
                state_next = lsa_pkg::S_READ;
            end
            lsa_pkg::S_EVAL: begin
                alu_req.a       = seq_reg;
                alu_req.b       = ent.seq;
                ev_found        = in_rng && ent.valid;
                ev_nb           = in_rng && ent.neighbor;
                res_status_next = lsa_pkg::STAT_OK;
                unique case (act_reg)
                    lsa_pkg::ACT_OFFER: begin
                        if (!in_rng) begin
                            res_status_next = lsa_pkg::STAT_NOTFOUND;
                        end else if (ent.valid && alu_rsp.lt) begin
                            res_status_next = lsa_pkg::STAT_STALE;
                            stale_cnt_next  = stale_cnt_reg + 32'd1;
                        end else if (ent.valid && alu_rsp.eq) begin
                            res_status_next = lsa_pkg::STAT_DUP;
                            dup_cnt_next    = dup_cnt_reg + 32'd1;
                        end else begin
                            upd_ent.neighbor = 1'b1;
                            upd_ent.valid    = 1'b1;
                            upd_ent.age      = age_reg;
                            upd_ent.seq      = seq_reg;
                            tbl_wr.en        = 1'b1;
                            rx_cnt_next      = rx_cnt_reg + 32'd1;
                            ev_found         = 1'b1;
                            ev_nb            = 1'b1;
                        end
                    end
                    lsa_pkg::ACT_REMOVE: begin
                        if (ev_found) begin
                            upd_ent.valid = 1'b0;
                            tbl_wr.en     = 1'b1;
                            ev_found      = 1'b0;
                        end else begin
                            res_status_next = lsa_pkg::STAT_NOTFOUND;
                        end
                    end
                    lsa_pkg::ACT_LOOKUP: begin
                        if (!ev_found) begin
                            res_status_next = lsa_pkg::STAT_NOTFOUND;
                        end
                    end
                    lsa_pkg::ACT_DROP: begin
                        if (in_rng) begin
                            upd_ent.neighbor = 1'b0;
                            tbl_wr.en        = 1'b1;
                            ev_nb            = 1'b0;
                        end else begin
                            res_status_next = lsa_pkg::STAT_NOTFOUND;
                        end
                    end
                    lsa_pkg::ACT_RESET_CNT: begin
                        rx_cnt_next    = '0;
                        dup_cnt_next   = '0;
                        stale_cnt_next = '0;
                    end
                    lsa_pkg::ACT_AGE, lsa_pkg::ACT_FLUSH, lsa_pkg::ACT_CLEAR: begin
                        res_status_next = lsa_pkg::STAT_OK;
                    end
                endcase
                tbl_wr.addr = rid_wide[lsa_pkg::ADDR_W-1:0];
                tbl_wr.data = upd_ent;

                res_next.found           = ev_found;
                res_next.stored_seq      = ev_found ? upd_ent.seq : '0;
                res_next.stored_age      = ev_found ? upd_ent.age : '0;
                res_next.is_neighbor     = ev_nb;
                res_next.flushed_count   = '0;
                if (act_reg == lsa_pkg::ACT_FLUSH) begin
                    res_next.flushed_count = (32'(flush_cnt_reg) > 32'(lsa_pkg::FLUSH_SAT))
                                           ? lsa_pkg::FLUSH_SAT
                                           : lsa_pkg::FLUSH_OUT_W'(flush_cnt_reg);
                end
                res_next.received_total  = rx_cnt_next;
                res_next.duplicate_total = dup_cnt_next;
                res_next.stale_total     = stale_cnt_next;
                state_next               = lsa_pkg::S_OUT;
            end
            lsa_pkg::S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = lsa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsa_pkg::S_IDLE;
            end
        endcase

        // sweep write-back stage: entry read last cycle
        if (pipe_vld_reg) begin
            alu_req.a   = lsa_pkg::ALU_W'(ent.age);
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = lsa_pkg::ADDR_W'(pipe_addr_reg);
            upd_ent     = ent;
            if (act_reg == lsa_pkg::ACT_AGE) begin
                alu_req.b = lsa_pkg::ALU_W'(1);
                if (ent.valid) begin
                    upd_ent.age = alu_rsp.sum[lsa_pkg::AGE_W] ? lsa_pkg::AGE_SAT
                                                              : alu_rsp.sum[lsa_pkg::AGE_W-1:0];
                end
            end else begin
                alu_req.b = lsa_pkg::ALU_W'(max_age_reg);
                if (ent.valid && !alu_rsp.lt) begin
                    upd_ent.valid  = 1'b0;
                    flush_cnt_next = flush_cnt_reg + FL_W'(1);
                    stale_cnt_next = stale_cnt_reg + 32'd1;
                end
            end
            tbl_wr.data = upd_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lsa_pkg::S_INIT;
            ptr_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            max_age_reg   <= lsa_pkg::MAX_AGE_RST;
            rx_cnt_reg    <= '0;
            dup_cnt_reg   <= '0;
            stale_cnt_reg <= '0;
            flush_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pipe_vld_reg  <= pipe_vld_next;
            max_age_reg   <= max_age_next;
            rx_cnt_reg    <= rx_cnt_next;
            dup_cnt_reg   <= dup_cnt_next;
            stale_cnt_reg <= stale_cnt_next;
            flush_cnt_reg <= flush_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_addr_reg  <= pipe_addr_next;
        act_reg        <= act_next;
        rid_reg        <= rid_next;
        seq_reg        <= seq_next;
        age_reg        <= age_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
        m_res_reg      <= m_res_next;
        m_status_reg   <= m_status_next;
    end

    `LSA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LSA_ASSERT_IMP(a_no_write_idle, aclk, aresetn, state_reg == lsa_pkg::S_IDLE, !tbl_wr.en)
    `LSA_ASSERT_NXT(a_result_from_out, aclk, aresetn, (state_reg != lsa_pkg::S_OUT) && !m_tvalid_reg, !m_tvalid_reg)
    `LSA_ASSERT_IMP(a_pipe_in_sweep, aclk, aresetn, pipe_vld_reg, (state_reg == lsa_pkg::S_SWEEP) || (state_reg == lsa_pkg::S_DRAIN))

endmodule
